### design/sm3_pkg.sv
// Package with the SM3 engine payload types, constants and round functions.
package sm3_pkg;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_beat_t;

	localparam logic MODE_ABSORB = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	localparam logic [31:0] IV0 = 32'h7380166f;
	localparam logic [31:0] IV1 = 32'h4914b2b9;
	localparam logic [31:0] IV2 = 32'h172442d7;
	localparam logic [31:0] IV3 = 32'hda8a0600;
	localparam logic [31:0] IV4 = 32'ha96f30bc;
	localparam logic [31:0] IV5 = 32'h163138aa;
	localparam logic [31:0] IV6 = 32'he38dee4d;
	localparam logic [31:0] IV7 = 32'hb0fb0e4e;
	localparam logic [31:0] T_LOW  = 32'h79cc4519;
	localparam logic [31:0] T_HIGH = 32'h7a879d8a;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	typedef enum logic [2:0] {
		BYTE_DATA,
		BYTE_PAD,
		BYTE_ZERO,
		BYTE_LEN
	} byte_src_t;

	typedef struct packed {
		logic      buf_we;
		byte_src_t buf_src;
		logic      len_add;
		logic      comp_start;
		logic      chain_init;
		logic      out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic comp_busy;
		logic comp_done;
	} dp_stat_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
		logic [63:0] d;
		d = {v, v} << n;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] v);
		return v ^ rotl(v, 5'd9) ^ rotl(v, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] v);
		return v ^ rotl(v, 5'd15) ^ rotl(v, 5'd23);
	endfunction

endpackage

### design/sm3_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module sm3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### design/sm3_datapath.sv
// Datapath: block buffer, message length, expansion window, rounds and chain value.
module sm3_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  sm3_pkg::dp_cmd_t   cmd,
	input  logic [5:0]         wpos,
	input  logic [7:0]         data_byte,
	input  logic [2:0]         out_idx,
	output sm3_pkg::dp_stat_t  stat,
	output logic [31:0]        out_word
);
	logic [7:0]  wbyte;
	logic [7:0]  rbyte;
	logic [5:0]  raddr;
	logic [63:0] len_q;
	logic [31:0] cv_q [8];
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [31:0] win_q [16];
	logic [31:0] word_acc_q;
	logic [6:0]  ld_q;
	logic        loading_q;
	logic        rd_vld_q;
	logic [6:0]  rnd_q;
	logic        running_q;
	logic        fin_q;
	logic [31:0] wnew;
	logic [31:0] w_k, wp_k, tk, a12, ss1, ss2, ffv, ggv, tt1, tt2;
	logic        lo;

	always_comb begin
		unique case (cmd.buf_src)
			sm3_pkg::BYTE_DATA: wbyte = data_byte;
			sm3_pkg::BYTE_PAD:  wbyte = sm3_pkg::PAD_BYTE;
			sm3_pkg::BYTE_LEN:  wbyte = len_q[8*(7-wpos[2:0]) +: 8];
			default:            wbyte = 8'h00;
		endcase
	end

	assign raddr = ld_q[5:0];

	sm3_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
		.clk(clk), .we(cmd.buf_we), .waddr(wpos), .wdata(wbyte),
		.raddr(raddr), .rdata(rbyte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.chain_init) begin
			len_q <= '0;
		end else if (cmd.len_add) begin
			len_q <= len_q + 64'd8;
		end
	end

	assign wnew = sm3_pkg::perm1(win_q[0] ^ win_q[7] ^ sm3_pkg::rotl(win_q[13], 5'd15))
		^ sm3_pkg::rotl(win_q[3], 5'd7) ^ win_q[10];
	assign lo   = (rnd_q < 7'd16);
	assign w_k  = win_q[0];
	assign wp_k = win_q[0] ^ win_q[4];
	assign tk   = lo ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
	assign a12  = sm3_pkg::rotl(a_q, 5'd12);
	assign ss1  = sm3_pkg::rotl(a12 + e_q + sm3_pkg::rotl(tk, rnd_q[4:0]), 5'd7);
	assign ss2  = ss1 ^ a12;
	assign ffv  = lo ? (a_q ^ b_q ^ c_q) : ((a_q & b_q) | (a_q & c_q) | (b_q & c_q));
	assign ggv  = lo ? (e_q ^ f_q ^ g_q) : ((e_q & f_q) | (~e_q & g_q));
	assign tt1  = ffv + d_q + ss2 + wp_k;
	assign tt2  = ggv + h_q + ss1 + w_k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loading_q <= 1'b0;
			rd_vld_q  <= 1'b0;
			running_q <= 1'b0;
			fin_q     <= 1'b0;
			ld_q      <= '0;
			rnd_q     <= '0;
			cv_q[0] <= sm3_pkg::IV0; cv_q[1] <= sm3_pkg::IV1;
			cv_q[2] <= sm3_pkg::IV2; cv_q[3] <= sm3_pkg::IV3;
			cv_q[4] <= sm3_pkg::IV4; cv_q[5] <= sm3_pkg::IV5;
			cv_q[6] <= sm3_pkg::IV6; cv_q[7] <= sm3_pkg::IV7;
		end else begin
			fin_q <= 1'b0;
			if (cmd.chain_init) begin
				cv_q[0] <= sm3_pkg::IV0; cv_q[1] <= sm3_pkg::IV1;
				cv_q[2] <= sm3_pkg::IV2; cv_q[3] <= sm3_pkg::IV3;
				cv_q[4] <= sm3_pkg::IV4; cv_q[5] <= sm3_pkg::IV5;
				cv_q[6] <= sm3_pkg::IV6; cv_q[7] <= sm3_pkg::IV7;
			end
			if (cmd.comp_start) begin
				loading_q <= 1'b1;
				ld_q      <= '0;
				rd_vld_q  <= 1'b0;
			end else if (loading_q) begin
				rd_vld_q <= 1'b1;
				if (ld_q != 7'd64) begin
					ld_q <= ld_q + 7'd1;
				end else begin
					loading_q <= 1'b0;
					rd_vld_q  <= 1'b0;
					running_q <= 1'b1;
					rnd_q     <= '0;
				end
			end else if (running_q) begin
				rnd_q <= rnd_q + 7'd1;
				if (rnd_q == 7'd63) begin
					running_q <= 1'b0;
					fin_q     <= 1'b1;
				end
			end
			if (fin_q) begin
				cv_q[0] <= cv_q[0] ^ a_q; cv_q[1] <= cv_q[1] ^ b_q;
				cv_q[2] <= cv_q[2] ^ c_q; cv_q[3] <= cv_q[3] ^ d_q;
				cv_q[4] <= cv_q[4] ^ e_q; cv_q[5] <= cv_q[5] ^ f_q;
				cv_q[6] <= cv_q[6] ^ g_q; cv_q[7] <= cv_q[7] ^ h_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (loading_q && rd_vld_q) begin
			word_acc_q <= {word_acc_q[23:0], rbyte};
			if (ld_q[1:0] == 2'd0) begin
				for (int i = 0; i < 15; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[15] <= {word_acc_q[23:0], rbyte};
			end
		end else if (running_q) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= wnew;
			a_q <= tt1;
			b_q <= a_q;
			c_q <= sm3_pkg::rotl(b_q, 5'd9);
			d_q <= c_q;
			e_q <= sm3_pkg::perm0(tt2);
			f_q <= e_q;
			g_q <= sm3_pkg::rotl(f_q, 5'd19);
			h_q <= g_q;
		end
		if (cmd.comp_start) begin
			a_q <= cv_q[0]; b_q <= cv_q[1]; c_q <= cv_q[2]; d_q <= cv_q[3];
			e_q <= cv_q[4]; f_q <= cv_q[5]; g_q <= cv_q[6]; h_q <= cv_q[7];
		end
	end

	assign stat.comp_busy = cmd.comp_start | loading_q | running_q | fin_q;
	assign stat.comp_done = fin_q;
	assign out_word = cv_q[out_idx];
endmodule

### design/sm3_ctrl.sv
// Controller: sequences absorb, padding, compression and digest output.
module sm3_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  sm3_pkg::in_beat_t  in_data,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  sm3_pkg::dp_stat_t  stat,
	output sm3_pkg::dp_cmd_t   cmd,
	output logic [5:0]         wpos,
	output logic [2:0]         out_idx
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_COMP  = 3'd1;
	localparam logic [2:0] S_PADZ  = 3'd2;
	localparam logic [2:0] S_LEN   = 3'd3;
	localparam logic [2:0] S_FCOMP = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0] state_q;
	logic [5:0] fill_q;
	logic [2:0] idx_q;
	logic       started_q;
	logic       second_q;
	logic       acc;

	assign in_stall  = (state_q != S_IDLE);
	assign acc       = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);
	assign out_idx   = idx_q;
	assign wpos      = fill_q;

	always_comb begin
		cmd = '0;
		cmd.buf_src = sm3_pkg::BYTE_ZERO;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					cmd.buf_we  = 1'b1;
					cmd.buf_src = (in_data.mode == sm3_pkg::MODE_ABSORB) ?
						sm3_pkg::BYTE_DATA : sm3_pkg::BYTE_PAD;
					cmd.len_add = (in_data.mode == sm3_pkg::MODE_ABSORB);
				end
			end
			S_PADZ: begin
				cmd.buf_we = 1'b1;
			end
			S_LEN: begin
				cmd.buf_we  = 1'b1;
				cmd.buf_src = sm3_pkg::BYTE_LEN;
			end
			S_COMP, S_FCOMP: begin
				cmd.comp_start = !started_q;
			end
			S_OUT: begin
				cmd.chain_init = !out_stall && (idx_q == 3'd7);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			idx_q     <= '0;
			started_q <= 1'b0;
			second_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						fill_q <= fill_q + 6'd1;
						if (in_data.mode == sm3_pkg::MODE_ABSORB) begin
							if (fill_q == 6'd63) begin
								state_q <= S_COMP;
							end
						end else begin
							second_q <= (fill_q >= 6'd56);
							if (fill_q == 6'd63) begin
								state_q <= S_FCOMP;
							end else if (fill_q == 6'd55) begin
								state_q <= S_LEN;
							end else begin
								state_q <= S_PADZ;
							end
						end
					end
				end
				S_PADZ: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						state_q <= S_FCOMP;
					end else if (fill_q == 6'd55 && !second_q) begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						state_q <= S_FCOMP;
					end
				end
				S_COMP, S_FCOMP: begin
					started_q <= 1'b1;
					if (stat.comp_done) begin
						started_q <= 1'b0;
						if (state_q == S_COMP) begin
							state_q <= S_IDLE;
						end else if (second_q) begin
							second_q <= 1'b0;
							state_q  <= S_PADZ;
						end else begin
							state_q <= S_OUT;
							idx_q   <= '0;
						end
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### design/sm3_hash_engine_unit.sv
// Top level of the SM3 hash engine.
// Input beats carry a mode bit and a message byte. Mode zero absorbs the byte
// into the 64-byte block buffer; mode one pads the message, hashes the final
// block or blocks and delivers the digest.
// An absorb beat that does not fill the block does not stall the input. The beat that
// fills a block stalls the input while the compression starts, the sixteen
// message words are reloaded from the block RAM, the 64 rounds run and the
// result is folded into the chain.
// A finish beat writes the padding one byte a cycle, runs one or two
// compressions, then shows eight output beats with words in big-endian order,
// index zero first and the last flag on index seven.
// While the output is stalled the current word holds and no input is taken.
// After the eighth word the chain value returns to the initial value, so the
// next message starts clean.
// Reset clears the chain value to the initial value, the byte count and the
// bit length; the block RAM holds no reset value and is always written first.
module sm3_hash_engine_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sm3_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sm3_pkg::out_beat_t  out_data
);
	sm3_pkg::dp_cmd_t  cmd;
	sm3_pkg::dp_stat_t stat;
	logic [5:0]  wpos;
	logic [2:0]  out_idx;
	logic [31:0] out_word;

	sm3_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_data(in_data),
		.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
		.stat(stat), .cmd(cmd), .wpos(wpos), .out_idx(out_idx)
	);

	sm3_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .wpos(wpos),
		.data_byte(in_data.data_byte), .out_idx(out_idx),
		.stat(stat), .out_word(out_word)
	);

	assign out_data.digest_word = out_word;
	assign out_data.word_index  = out_idx;
	assign out_data.last_word   = (out_idx == 3'd7);
endmodule

### design/sm3_checker.sv
// Port-level checker for the SM3 hash engine and its bind.
module sm3_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input sm3_pkg::out_beat_t  out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output beat changed");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_word == (out_data.word_index == 3'd7)))
		else $error("last flag does not match index seven");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.last_word |=>
		out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
		else $error("digest words not consecutive");

	a_no_input_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while digest is delivered");
endmodule

bind sm3_hash_engine_unit sm3_checker u_sm3_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

### sim/sm3_digest_checker.sv
// Checker that predicts SM3 digests from accepted input beats and compares the output beats.
module sm3_digest_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  sm3_pkg::in_beat_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  sm3_pkg::out_beat_t out_data,
	output int                 fail_count,
	output int                 words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [31:0] chain [8];
	logic [7:0]  msg_block [64];
	logic [5:0]  fill;
	logic [63:0] bit_len;
	sm3_pkg::out_beat_t digest_q [$];

	function automatic logic [31:0] rol(logic [31:0] v, int n);
		n = n % 32;
		if (n == 0) begin
			return v;
		end
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] p0(logic [31:0] v);
		return v ^ rol(v, 9) ^ rol(v, 17);
	endfunction

	function automatic logic [31:0] p1(logic [31:0] v);
		return v ^ rol(v, 15) ^ rol(v, 23);
	endfunction

	task automatic compress();
		logic [31:0] w [68];
		logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
		for (int k = 0; k < 16; k++) begin
			w[k] = {msg_block[4*k], msg_block[4*k+1], msg_block[4*k+2], msg_block[4*k+3]};
		end
		for (int k = 16; k < 68; k++) begin
			w[k] = p1(w[k-16] ^ w[k-9] ^ rol(w[k-3], 15)) ^ rol(w[k-13], 7) ^ w[k-6];
		end
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (int k = 0; k < 64; k++) begin
			tj = (k < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
			a12 = rol(a, 12);
			ss1 = rol(a12 + e + rol(tj, k), 7);
			ss2 = ss1 ^ a12;
			if (k < 16) begin
				ff = a ^ b ^ c;
				gg = e ^ f ^ g;
			end else begin
				ff = (a & b) | (a & c) | (b & c);
				gg = (e & f) | (~e & g);
			end
			tt1 = ff + d + ss2 + (w[k] ^ w[k+4]);
			tt2 = gg + h + ss1 + w[k];
			d = c; c = rol(b, 9); b = a; a = tt1;
			h = g; g = rol(f, 19); f = e; e = p0(tt2);
		end
		chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
		chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
	endtask

	task automatic restart();
		chain = '{sm3_pkg::IV0, sm3_pkg::IV1, sm3_pkg::IV2, sm3_pkg::IV3,
			sm3_pkg::IV4, sm3_pkg::IV5, sm3_pkg::IV6, sm3_pkg::IV7};
		fill = '0;
		bit_len = '0;
	endtask

	task automatic take_beat(sm3_pkg::in_beat_t beat);
		int pos;
		sm3_pkg::out_beat_t ob;
		if (beat.mode == sm3_pkg::MODE_ABSORB) begin
			bit_len += 64'd8;
			msg_block[fill] = beat.data_byte;
			fill++;
			if (fill == 0) begin
				compress();
			end
			return;
		end
		pos = fill;
		msg_block[pos] = sm3_pkg::PAD_BYTE;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			compress();
			pos = 0;
		end
		while (pos < 56) begin
			msg_block[pos] = 8'h00;
			pos++;
		end
		for (int k = 0; k < 8; k++) begin
			msg_block[56+k] = bit_len[8*(7-k) +: 8];
		end
		compress();
		for (int k = 0; k < 8; k++) begin
			ob.digest_word = chain[k];
			ob.word_index = 3'(k);
			ob.last_word = (k == 7);
			digest_q.push_back(ob);
		end
		restart();
	endtask

	initial begin
		fail_count = 0;
		restart();
	end

	assign words_pending = digest_q.size();

	always @(posedge clk) begin
		sm3_pkg::out_beat_t exp_beat;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					$display("%0t: unexpected digest beat %h", $time, out_data);
					fail_count++;
				end else begin
					exp_beat = digest_q.pop_front();
					if (exp_beat.digest_word !== out_data.digest_word
							|| exp_beat.word_index !== out_data.word_index
							|| exp_beat.last_word !== out_data.last_word) begin
						$display("%0t: digest beat mismatch, expected %h actual %h",
							$time, exp_beat, out_data);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				take_beat(in_data);
			end
		end
	end
endmodule

### sim/tb.sv
// Testbench top for the SM3 hash engine: stimulus, stall pattern and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STUCK_LIMIT = 20000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	sm3_pkg::in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	sm3_pkg::out_beat_t out_data;
	int        fail_count;
	int        words_pending;
	int        idle_pct;
	int        quiet_cycles;

	sm3_hash_engine_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	sm3_digest_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .words_pending(words_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < idle_pct);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles > STUCK_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic send(logic mode, logic [7:0] value);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{mode: mode, data_byte: value};
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic hash_message(int len);
		for (int k = 0; k < len; k++) begin
			send(sm3_pkg::MODE_ABSORB, 8'($urandom));
		end
		send(sm3_pkg::MODE_FINISH, 8'($urandom));
	endtask

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		idle_pct = 8;
		quiet_cycles = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Empty message, then "abc", then a four-byte message.
		send(sm3_pkg::MODE_FINISH, 8'hff);
		send(sm3_pkg::MODE_ABSORB, 8'h61);
		send(sm3_pkg::MODE_ABSORB, 8'h62);
		send(sm3_pkg::MODE_ABSORB, 8'h63);
		send(sm3_pkg::MODE_FINISH, 8'h00);
		send(sm3_pkg::MODE_ABSORB, 8'h00);
		send(sm3_pkg::MODE_ABSORB, 8'hff);
		send(sm3_pkg::MODE_ABSORB, 8'h55);
		send(sm3_pkg::MODE_ABSORB, 8'haa);
		send(sm3_pkg::MODE_FINISH, 8'h5a);
		hash_message(56);
		hash_message(55);
		idle_pct = 0;
		hash_message(64);
		idle_pct = 8;
		for (int n = 0; n < 2; n++) begin
			hash_message($urandom_range(0, 80));
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b0;
		repeat (300) @(posedge clk);
		if (fail_count == 0 && words_pending == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end
endmodule

### filelist.f
design/sm3_pkg.sv
design/sm3_ram.sv
design/sm3_datapath.sv
design/sm3_ctrl.sv
design/sm3_hash_engine_unit.sv
design/sm3_checker.sv
sim/sm3_digest_checker.sv
sim/tb.sv
